// ===== rtl/lpcmhd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpcmhd_pkg
// Types and codes shared by the LPCM header decoder modules.
// ----------------------------------------------------------------------------
package lpcmhd_pkg;

  typedef enum logic [1:0] {
    FMT_NONE = 2'd0,
    FMT_VOB  = 2'd1,
    FMT_DVD  = 2'd2,
    FMT_BR   = 2'd3
  } fmt_t;

  typedef struct packed {
    logic [7:0]  header_byte_0;
    logic [7:0]  header_byte_1;
    logic [7:0]  header_byte_2;
    logic [7:0]  header_byte_3;
    logic [7:0]  header_byte_4;
    logic [7:0]  header_byte_5;
    logic [7:0]  header_byte_6;
    logic [7:0]  header_byte_7;
    logic [7:0]  header_byte_9;
    logic [15:0] available_bytes;
  } in_beat_t;

  typedef struct packed {
    logic        header_valid;
    logic [17:0] sample_rate;
    logic [3:0]  channel_count;
    logic [4:0]  sample_bits;
    logic [10:0] speaker_mask;
    logic [22:0] byte_rate;
    logic [3:0]  header_length;
  } out_beat_t;

  // decoded header, before the byte rate is formed
  typedef struct packed {
    logic        ok;
    logic [17:0] rate;
    logic [3:0]  chans;
    logic [4:0]  bits;
    logic [10:0] mask;
    logic [3:0]  hlen;
  } dec_t;

endpackage

// ===== rtl/lpcmhd_if.sv =====
// ----------------------------------------------------------------------------
// lpcmhd_in_if / lpcmhd_out_if
// Valid/ready channels carrying header beats and decode result beats.
// ----------------------------------------------------------------------------
interface lpcmhd_in_if;
  import lpcmhd_pkg::*;

  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lpcmhd_out_if;
  import lpcmhd_pkg::*;

  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lpcmhd_decode.sv =====
// ----------------------------------------------------------------------------
// lpcmhd_decode
// First stage: layout decode, range checks and table look-ups, registered.
// ----------------------------------------------------------------------------
module lpcmhd_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lpcmhd_pkg::fmt_t      fmt,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lpcmhd_pkg::in_beat_t  in_data,
  output logic                  dec_valid,
  input  logic                  dec_ready,
  output lpcmhd_pkg::dec_t      dec_data
);
  import lpcmhd_pkg::*;

  function automatic logic [10:0] vob_mask(input logic [2:0] c);
    case (c)
      3'd0:    vob_mask = 11'h004;
      3'd1:    vob_mask = 11'h003;
      3'd2:    vob_mask = 11'h00B;
      3'd3:    vob_mask = 11'h033;
      3'd4:    vob_mask = 11'h03B;
      3'd5:    vob_mask = 11'h03F;
      3'd6:    vob_mask = 11'h6C7;
      default: vob_mask = 11'h0FF;
    endcase
  endfunction

  function automatic logic [2:0] dvd_cnt1(input logic [4:0] a);
    case (a) inside
      5'd0:          dvd_cnt1 = 3'd1;
      [5'd1:5'd12]:  dvd_cnt1 = 3'd2;
      [5'd13:5'd17]: dvd_cnt1 = 3'd3;
      default:       dvd_cnt1 = 3'd4;
    endcase
  endfunction

  function automatic logic [10:0] dvd_msk1(input logic [4:0] a);
    case (a) inside
      5'd0:          dvd_msk1 = 11'h004;
      [5'd1:5'd12]:  dvd_msk1 = 11'h003;
      [5'd13:5'd17]: dvd_msk1 = 11'h007;
      default:       dvd_msk1 = 11'h033;
    endcase
  endfunction

  function automatic logic [2:0] dvd_cnt2(input logic [4:0] a);
    case (a)
      5'd2, 5'd4, 5'd7, 5'd13, 5'd15, 5'd18, 5'd19: dvd_cnt2 = 3'd1;
      5'd3, 5'd5, 5'd8, 5'd10, 5'd14, 5'd16, 5'd20: dvd_cnt2 = 3'd2;
      5'd6, 5'd9, 5'd11, 5'd17:                     dvd_cnt2 = 3'd3;
      5'd12:                                        dvd_cnt2 = 3'd4;
      default:                                      dvd_cnt2 = 3'd0;
    endcase
  endfunction

  function automatic logic [10:0] dvd_msk2(input logic [4:0] a);
    case (a)
      5'd2, 5'd13:         dvd_msk2 = 11'h100;
      5'd3, 5'd14:         dvd_msk2 = 11'h600;
      5'd4, 5'd15, 5'd18:  dvd_msk2 = 11'h008;
      5'd5, 5'd16:         dvd_msk2 = 11'h108;
      5'd6, 5'd17:         dvd_msk2 = 11'h608;
      5'd7, 5'd19:         dvd_msk2 = 11'h004;
      5'd8:                dvd_msk2 = 11'h104;
      5'd9:                dvd_msk2 = 11'h604;
      5'd10, 5'd20:        dvd_msk2 = 11'h00C;
      5'd11:               dvd_msk2 = 11'h10C;
      5'd12:               dvd_msk2 = 11'h60C;
      default:             dvd_msk2 = 11'h000;
    endcase
  endfunction

  function automatic logic [3:0] br_cnt(input logic [3:0] c);
    case (c)
      4'd1:    br_cnt = 4'd1;
      4'd3:    br_cnt = 4'd2;
      4'd4:    br_cnt = 4'd3;
      4'd5:    br_cnt = 4'd3;
      4'd6:    br_cnt = 4'd4;
      4'd7:    br_cnt = 4'd4;
      4'd8:    br_cnt = 4'd5;
      4'd9:    br_cnt = 4'd6;
      4'd10:   br_cnt = 4'd7;
      4'd11:   br_cnt = 4'd8;
      default: br_cnt = 4'd0;
    endcase
  endfunction

  function automatic logic [10:0] br_msk(input logic [3:0] c);
    case (c)
      4'd1:    br_msk = 11'h004;
      4'd3:    br_msk = 11'h003;
      4'd4:    br_msk = 11'h007;
      4'd5:    br_msk = 11'h103;
      4'd6:    br_msk = 11'h107;
      4'd7:    br_msk = 11'h033;
      4'd8:    br_msk = 11'h037;
      4'd9:    br_msk = 11'h03F;
      4'd10:   br_msk = 11'h637;
      4'd11:   br_msk = 11'h63F;
      default: br_msk = 11'h000;
    endcase
  endfunction

  logic        v_r;
  dec_t        d_r;
  dec_t        d_nxt;

  logic [7:0]  vb;
  logic [15:0] dlen;
  logic [3:0]  sz1, sz2, rt1, rt2;
  logic [7:0]  asg;
  logic [4:0]  ai;
  logic        dvd_ok, dvd_g2;
  logic [17:0] dvd_base;
  logic [3:0]  bcc, brc;
  logic [1:0]  bwc;
  logic        br_ok;

  always_comb begin
    vb   = in_data.header_byte_4;
    dlen = {in_data.header_byte_1, in_data.header_byte_2};
    sz1  = in_data.header_byte_6[7:4];
    sz2  = in_data.header_byte_6[3:0];
    rt1  = in_data.header_byte_7[7:4];
    rt2  = in_data.header_byte_7[3:0];
    asg  = in_data.header_byte_9;
    ai   = asg[4:0];
    bcc  = in_data.header_byte_2[7:4];
    brc  = in_data.header_byte_2[3:0];
    bwc  = in_data.header_byte_3[7:6];

    // length field + 3 must reach 11
    dvd_ok = (dlen >= 16'd8) && (sz1 <= 4'd2) && (sz2 == 4'hF || sz2 <= 4'd2) &&
             (rt1[2:0] <= 3'd2) && (rt2 == 4'hF || rt2[2:0] <= 3'd2) &&
             (asg <= 8'd20);
    dvd_g2   = (sz2 != 4'hF) && (rt2 != 4'hF) && (sz1 == sz2) && (rt1 == rt2);
    dvd_base = rt1[3] ? 18'd44100 : 18'd48000;
    br_ok    = (br_cnt(bcc) != 4'd0) && (bwc != 2'd0) &&
               (brc == 4'd1 || brc == 4'd4 || brc == 4'd5);

    d_nxt = '0;
    unique case (fmt)
      FMT_VOB: begin
        if (in_data.available_bytes >= 16'd6 && in_data.header_byte_5 == 8'h80) begin
          d_nxt.ok = 1'b1;
          case (vb[5:4])
            2'd0:    d_nxt.rate = 18'd48000;
            2'd1:    d_nxt.rate = 18'd96000;
            2'd2:    d_nxt.rate = 18'd44100;
            default: d_nxt.rate = 18'd32000;
          endcase
          d_nxt.chans = {1'b0, vb[2:0]} + 4'd1;
          case (vb[7:6])
            2'd1:    d_nxt.bits = 5'd20;
            2'd2:    d_nxt.bits = 5'd24;
            default: d_nxt.bits = 5'd16;
          endcase
          d_nxt.mask = vob_mask(vb[2:0]);
          d_nxt.hlen = 4'd6;
        end
      end
      FMT_DVD: begin
        if (dvd_ok) begin
          d_nxt.ok    = 1'b1;
          d_nxt.bits  = 5'd16 + {1'b0, sz1[1:0], 2'b00};
          d_nxt.rate  = dvd_base << rt1[1:0];
          d_nxt.chans = {1'b0, dvd_cnt1(ai)} + (dvd_g2 ? {1'b0, dvd_cnt2(ai)} : 4'd0);
          d_nxt.mask  = dvd_msk1(ai) | (dvd_g2 ? dvd_msk2(ai) : 11'h000);
          d_nxt.hlen  = 4'd11;
        end
      end
      FMT_BR: begin
        if (br_ok) begin
          d_nxt.ok = 1'b1;
          case (brc)
            4'd1:    d_nxt.rate = 18'd48000;
            4'd4:    d_nxt.rate = 18'd96000;
            default: d_nxt.rate = 18'd192000;
          endcase
          d_nxt.chans = br_cnt(bcc);
          d_nxt.mask  = br_msk(bcc);
          d_nxt.bits  = (bwc == 2'd1) ? 5'd16 : 5'd24;
          d_nxt.hlen  = 4'd4;
        end
      end
      default: d_nxt = '0;
    endcase
  end

  assign in_ready  = !v_r || dec_ready;
  assign dec_valid = v_r;
  assign dec_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      d_r <= d_nxt;
    end
  end

endmodule

// ===== rtl/lpcmhd_rate.sv =====
// ----------------------------------------------------------------------------
// lpcmhd_rate
// Second and third stages: byte rate as rate x channels, then x bits / 8.
// ----------------------------------------------------------------------------
module lpcmhd_rate (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   dec_valid,
  output logic                   dec_ready,
  input  lpcmhd_pkg::dec_t       dec_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lpcmhd_pkg::out_beat_t  out_data
);
  import lpcmhd_pkg::*;

  logic        v2_r;
  dec_t        d2_r;
  logic [21:0] p2_r;
  logic [21:0] p2_nxt;
  logic        ready2;

  logic        v3_r;
  out_beat_t   o3_r;
  out_beat_t   o3_nxt;
  logic [26:0] p3;

  assign ready2    = !v3_r || out_ready;
  assign dec_ready = !v2_r || ready2;
  assign p2_nxt    = 22'(dec_data.rate) * 22'(dec_data.chans);

  always_comb begin
    p3 = 27'(p2_r) * 27'(d2_r.bits);
    o3_nxt.header_valid  = d2_r.ok;
    o3_nxt.sample_rate   = d2_r.rate;
    o3_nxt.channel_count = d2_r.chans;
    o3_nxt.sample_bits   = d2_r.bits;
    o3_nxt.speaker_mask  = d2_r.mask;
    o3_nxt.byte_rate     = p3[25:3];
    o3_nxt.header_length = d2_r.hlen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (dec_ready) v2_r <= dec_valid;
      if (ready2)    v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_valid && dec_ready) begin
      d2_r <= dec_data;
      p2_r <= p2_nxt;
    end
    if (v2_r && ready2) begin
      o3_r <= o3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = o3_r;

endmodule

// ===== rtl/lpcm_header_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// lpcm_header_decoder_unit
// LPCM audio packet header decoder for VOB, DVD-Audio and Blu-ray layouts.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_wdata set the header layout (0 none, 1 VOB, 2 DVD-Audio,
//   3 Blu-ray); write it only while the pipeline is empty.
//   in_ch takes one header beat (packet bytes and available byte count);
//   out_ch gives one result beat per header, in order. Rejected headers give
//   a beat with every field zero.
// Pipeline: three register stages from input beat to result beat: decode,
//   rate x channels, x bits / 8 into the output register.
// Throughput: one beat per cycle while out_ch.ready is not held low.
// Reset: synchronous, active low; empties the pipeline and selects layout 0.
// Stall: each stage holds while the next is full and stalled; bubbles close
//   up, so in_ch.ready drops only when all three stages hold beats.
// ----------------------------------------------------------------------------
module lpcm_header_decoder_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_wdata,
  lpcmhd_in_if.sink    in_ch,
  lpcmhd_out_if.source out_ch
);
  import lpcmhd_pkg::*;

  fmt_t fmt_r;
  logic dec_valid;
  logic dec_ready;
  dec_t dec_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_NONE;
    end else if (cfg_we) begin
      fmt_r <= fmt_t'(cfg_wdata);
    end
  end

  lpcmhd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .fmt       (fmt_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_data  (dec_data)
  );

  lpcmhd_rate u_rate (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_data  (dec_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

endmodule
